@@ rtl/wdf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Parse phases, frame kinds, length codes and the result record shared by
// the deframer modules.
// ----------------------------------------------------------------------------
package wdf_pkg;

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_TEXT    = 2'd0,
      KIND_CLOSE   = 2'd1,
      KIND_UNKNOWN = 2'd2
   } kind_type;

   localparam logic [6:0] LEN_CODE16  = 7'd126;
   localparam logic [6:0] LEN_CODE64  = 7'd127;
   localparam logic [3:0] EXT_BYTES16 = 4'd2;
   localparam logic [3:0] EXT_BYTES64 = 4'd8;

   typedef struct packed {
      kind_type    frame_kind;
      logic        final_flag;
      logic        masked_flag;
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        frame_last;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/wdf_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer channels
// Byte request channel and frame result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] frame_kind;
   logic       final_flag;
   logic       masked_flag;
   logic [7:0] payload_byte;
   logic       payload_valid;
   logic       frame_last;

   modport source (output valid, output frame_kind, output final_flag,
                   output masked_flag, output payload_byte,
                   output payload_valid, output frame_last, input ready);
   modport sink   (input valid, input frame_kind, input final_flag,
                   input masked_flag, input payload_byte,
                   input payload_valid, input frame_last, output ready);
endinterface
`default_nettype wire

@@ rtl/wdf_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Frame state registers and the single-pass byte parse: header, extended
// length, mask key and payload unmasking.
// ----------------------------------------------------------------------------
module wdf_parser import wdf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output rsp_type    result,
   output logic       result_valid
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  pos_ff, pos_in;
   logic        final_ff, final_in;
   logic        masked_ff, masked_in;
   kind_type    kind_ff, kind_in;

   logic        ext_done;
   logic        key_done;
   logic        rem_zero;
   logic        data_last;
   logic [4:0]  key_shift;
   logic [6:0]  len_code;

   assign ext_done  = (ext_left_ff == 4'd1);
   assign key_done  = (pos_ff == 2'd3);
   assign rem_zero  = (remaining_ff == 64'd0);
   assign data_last = (remaining_ff == 64'd1);
   assign key_shift = {~pos_ff, 3'b000};
   assign len_code  = rx_byte[6:0];

   // next phase
   always_comb begin
      case (phase_ff)
         PH_HDR1: begin
            if (kind_ff != KIND_TEXT) begin
               phase_in = PH_HDR0;
            end else if (len_code == LEN_CODE16 || len_code == LEN_CODE64) begin
               phase_in = PH_EXT;
            end else begin
               phase_in = PH_KEY;
            end
         end
         PH_EXT:  phase_in = ext_done ? PH_KEY : PH_EXT;
         PH_KEY: begin
            if (!key_done) begin
               phase_in = PH_KEY;
            end else if (rem_zero) begin
               phase_in = PH_HDR0;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: phase_in = data_last ? PH_HDR0 : PH_DATA;
         default: phase_in = PH_HDR1;
      endcase
   end

   // datapath and result
   always_comb begin
      ext_left_in  = ext_left_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      final_in     = final_ff;
      masked_in    = masked_ff;
      kind_in      = kind_ff;
      result_valid = 1'b0;
      result.frame_kind    = KIND_TEXT;
      result.payload_byte  = 8'd0;
      result.payload_valid = 1'b0;
      result.frame_last    = 1'b0;
      case (phase_ff)
         PH_HDR1: begin
            masked_in = rx_byte[7];
            if (kind_ff != KIND_TEXT) begin
               result_valid      = 1'b1;
               result.frame_kind = kind_ff;
               result.frame_last = 1'b1;
            end else begin
               pos_in = 2'd0;
               if (len_code == LEN_CODE16) begin
                  ext_left_in  = EXT_BYTES16;
                  remaining_in = 64'd0;
               end else if (len_code == LEN_CODE64) begin
                  ext_left_in  = EXT_BYTES64;
                  remaining_in = 64'd0;
               end else begin
                  ext_left_in  = 4'd0;
                  remaining_in = {57'd0, len_code};
               end
            end
         end
         PH_EXT: begin
            remaining_in = {remaining_ff[55:0], rx_byte};
            ext_left_in  = ext_left_ff - 4'd1;
            if (ext_done) begin
               pos_in = 2'd0;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], rx_byte};
            pos_in = pos_ff + 2'd1;
            if (key_done && rem_zero) begin
               result_valid      = 1'b1;
               result.frame_last = 1'b1;
            end
         end
         PH_DATA: begin
            remaining_in         = remaining_ff - 64'd1;
            pos_in               = data_last ? 2'd0 : pos_ff + 2'd1;
            result_valid         = 1'b1;
            result.payload_byte  = rx_byte ^ key_ff[key_shift +: 8];
            result.payload_valid = 1'b1;
            result.frame_last    = data_last;
         end
         default: begin
            final_in = rx_byte[7];
            if (rx_byte[0]) begin
               kind_in = KIND_TEXT;
            end else if (rx_byte[3]) begin
               kind_in = KIND_CLOSE;
            end else begin
               kind_in = KIND_UNKNOWN;
            end
         end
      endcase
      result.final_flag  = final_in;
      result.masked_flag = masked_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         ext_left_ff  <= 4'd0;
         remaining_ff <= 64'd0;
         key_ff       <= 32'd0;
         pos_ff       <= 2'd0;
         final_ff     <= 1'b0;
         masked_ff    <= 1'b0;
         kind_ff      <= KIND_TEXT;
      end else if (step) begin
         phase_ff     <= phase_in;
         ext_left_ff  <= ext_left_in;
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         pos_ff       <= pos_in;
         final_ff     <= final_in;
         masked_ff    <= masked_in;
         kind_ff      <= kind_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/wdf_out_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module wdf_out_stage import wdf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  rsp_type    result,
   output logic       busy,
   wdf_rsp_if.source  rsp_if
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign busy                 = valid_ff;
   assign rsp_if.valid         = valid_ff;
   assign rsp_if.frame_kind    = data_ff.frame_kind;
   assign rsp_if.final_flag    = data_ff.final_flag;
   assign rsp_if.masked_flag   = data_ff.masked_flag;
   assign rsp_if.payload_byte  = data_ff.payload_byte;
   assign rsp_if.payload_valid = data_ff.payload_valid;
   assign rsp_if.frame_last    = data_ff.frame_last;

endmodule
`default_nettype wire

@@ rtl/websocket_frame_deframer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side frame parser: one stream byte in, at most one result out.
//
// req_if carries one received byte per transfer. rsp_if carries frame
// results: unmasked payload bytes of text frames, one empty last result for
// a zero-length text frame, and one kind result at header byte 1 of close
// and unknown frames. Other header, extended-length and key bytes give no result.
// A byte is held in the input register and then parsed into the result
// register, from which its result shows on rsp_if. Throughput: one byte per
// cycle while rsp_if does not stall; the parse of a byte is a single pass
// through the phase logic and the unmask XOR.
// When rsp_if stalls, the result register holds and one more byte waits in
// the input register; req_if.ready then drops. Bytes that give no result
// still wait for a free result register.
// Reset clears the phase to header byte 0, the length, key and flags, and
// empties both registers.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wdf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   wdf_req_if.sink   req_if,
   wdf_rsp_if.source rsp_if
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       advance;
   logic       out_busy;
   logic       req_xfer;
   rsp_type    result;
   logic       result_valid;

   assign advance      = s1_valid_ff && (!out_busy || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_xfer     = req_if.valid && req_if.ready;

   always_comb begin
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff <= req_if.rx_byte;
      end
   end

   wdf_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (s1_byte_ff),
      .result       (result),
      .result_valid (result_valid)
   );

   wdf_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && result_valid),
      .result (result),
      .busy   (out_busy),
      .rsp_if (rsp_if)
   );

   a_payload_text: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.payload_valid) |-> (rsp_if.frame_kind == KIND_TEXT))
      else $error("payload byte on a non-text result");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.payload_valid) |-> (rsp_if.payload_byte == 8'd0))
      else $error("nonzero payload byte without payload_valid");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!advance && !rsp_if.valid) |=> !rsp_if.valid)
      else $error("result appeared without a parsed byte");

endmodule
`default_nettype wire
